@@ rtl/avri_pkg.sv @@
`default_nettype none

package avri_pkg;

   // Input coordinate width and fraction bits of the map coefficients
   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS = 16;

   // Fixed field and register widths
   localparam int COEF_BITS = 32;
   localparam int EXT_BITS = 16;
   localparam int CSR_DATA_BITS = 64;
   localparam int EXTENTS_BITS = 3 * EXT_BITS;
   localparam int IDX_BITS = 36;
   localparam int ROW_BITS = 2 * EXT_BITS;
   localparam int LIN_BITS = ROW_BITS + EXT_BITS;

   // Derived arithmetic widths: product, three-term sum plus offset, rounded position
   localparam int PROD_BITS = COEF_BITS + COORD_BITS + 1;
   localparam int ACC_BITS = PROD_BITS + 2;
   localparam int POS_BITS = ACC_BITS - FRAC_BITS;
   localparam int CMP_BITS = ((POS_BITS > EXT_BITS) ? POS_BITS : EXT_BITS) + 1;

   // Fraction value of one half, the rounding tie point
   localparam logic [FRAC_BITS-1:0] HALF_UNIT = FRAC_BITS'(1) << (FRAC_BITS - 1);

   // Configuration register indexes
   localparam int CSR_IDX_BITS = 3;
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MAP_X_LO   = 3'd0,
      CSR_MAP_X_HI   = 3'd1,
      CSR_MAP_Y_LO   = 3'd2,
      CSR_MAP_Y_HI   = 3'd3,
      CSR_MAP_Z_LO   = 3'd4,
      CSR_MAP_Z_HI   = 3'd5,
      CSR_EXTENTS    = 3'd6
   } csr_index_type;

   // Reset values: identity map, empty moving volume
   localparam logic [CSR_DATA_BITS-1:0] RST_MAP_X_LO = 64'h0000_0000_0001_0000;
   localparam logic [CSR_DATA_BITS-1:0] RST_MAP_X_HI = 64'h0000_0000_0000_0000;
   localparam logic [CSR_DATA_BITS-1:0] RST_MAP_Y_LO = 64'h0001_0000_0000_0000;
   localparam logic [CSR_DATA_BITS-1:0] RST_MAP_Y_HI = 64'h0000_0000_0000_0000;
   localparam logic [CSR_DATA_BITS-1:0] RST_MAP_Z_LO = 64'h0000_0000_0000_0000;
   localparam logic [CSR_DATA_BITS-1:0] RST_MAP_Z_HI = 64'h0000_0000_0001_0000;
   localparam logic [EXTENTS_BITS-1:0] RST_EXTENTS = '0;

   // One rounded axis position on its way to the index stages
   typedef struct packed {
      logic [EXT_BITS-1:0] pos;
      logic                in_range;
   } axis_pos_type;

endpackage

`default_nettype wire

@@ rtl/avri_axis.sv @@
`default_nettype none

module avri_axis (
   input  wire logic                               clock,
   input  wire logic                               advance,
   input  wire logic [avri_pkg::COORD_BITS-1:0]    ref_x,
   input  wire logic [avri_pkg::COORD_BITS-1:0]    ref_y,
   input  wire logic [avri_pkg::COORD_BITS-1:0]    ref_z,
   input  wire logic [avri_pkg::CSR_DATA_BITS-1:0] row_lo,
   input  wire logic [avri_pkg::CSR_DATA_BITS-1:0] row_hi,
   input  wire logic [avri_pkg::EXT_BITS-1:0]      extent,
   output avri_pkg::axis_pos_type                  axis_out
);
   import avri_pkg::*;

   logic signed [PROD_BITS-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [PROD_BITS-1:0] prod_x_in, prod_y_in, prod_z_in;
   logic signed [ACC_BITS-1:0]  acc;
   logic [POS_BITS-1:0]         floor_v;
   logic [FRAC_BITS-1:0]        frac;
   logic                        round_up;
   logic signed [POS_BITS-1:0]  rnd;
   logic signed [CMP_BITS-1:0]  rnd_w;
   logic [CMP_BITS-1:0]         ext_w;
   axis_pos_type                axis_ff, axis_in;

   // Multiply each coordinate by its signed coefficient
   always_comb begin
      prod_x_in = $signed(row_lo[COEF_BITS-1:0]) * $signed({1'b0, ref_x});
      prod_y_in = $signed(row_lo[2*COEF_BITS-1:COEF_BITS]) * $signed({1'b0, ref_y});
      prod_z_in = $signed(row_hi[COEF_BITS-1:0]) * $signed({1'b0, ref_z});
   end

   // Sum the products with the offset, round to nearest with ties to even, check bounds
   always_comb begin
      acc = ACC_BITS'(prod_x_ff) + ACC_BITS'(prod_y_ff) + ACC_BITS'(prod_z_ff)
          + ACC_BITS'($signed(row_hi[2*COEF_BITS-1:COEF_BITS]));
      floor_v = acc[ACC_BITS-1:FRAC_BITS];
      frac = acc[FRAC_BITS-1:0];
      round_up = (frac > HALF_UNIT) || ((frac == HALF_UNIT) && floor_v[0]);
      rnd = $signed(floor_v + {{(POS_BITS-1){1'b0}}, round_up});
      rnd_w = CMP_BITS'(rnd);
      ext_w = CMP_BITS'(extent);
      axis_in.pos = rnd_w[EXT_BITS-1:0];
      axis_in.in_range = !rnd_w[CMP_BITS-1] && (unsigned'(rnd_w) < ext_w);
   end

   // Advance both stages together
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
         axis_ff <= axis_in;
      end
   end

   assign axis_out = axis_ff;

endmodule

`default_nettype wire

@@ rtl/avri_index.sv @@
`default_nettype none

module avri_index (
   input  wire logic                          clock,
   input  wire logic                          advance,
   input  wire avri_pkg::axis_pos_type        pos_x,
   input  wire avri_pkg::axis_pos_type        pos_y,
   input  wire avri_pkg::axis_pos_type        pos_z,
   input  wire logic [avri_pkg::EXT_BITS-1:0] extent_x,
   input  wire logic [avri_pkg::EXT_BITS-1:0] extent_y,
   output logic [avri_pkg::IDX_BITS-1:0]      moving_index,
   output logic                               in_bounds
);
   import avri_pkg::*;

   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [EXT_BITS-1:0] col_ff;
   logic                inside_ff, inside_in;
   logic [LIN_BITS-1:0] lin;
   logic [IDX_BITS-1:0] index_ff, index_in;
   logic                bounds_ff;

   // Row offset: slice times rows plus row
   always_comb begin
      inside_in = pos_x.in_range && pos_y.in_range && pos_z.in_range;
      row_in = ROW_BITS'(pos_z.pos) * ROW_BITS'(extent_y) + ROW_BITS'(pos_y.pos);
   end

   // Linear index: row offset times columns plus column, zero when outside
   always_comb begin
      lin = LIN_BITS'(row_ff) * LIN_BITS'(extent_x) + LIN_BITS'(col_ff);
      index_in = inside_ff ? lin[IDX_BITS-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         row_ff <= row_in;
         col_ff <= pos_x.pos;
         inside_ff <= inside_in;
         index_ff <= index_in;
         bounds_ff <= inside_ff;
      end
   end

   assign moving_index = index_ff;
   assign in_bounds = bounds_ff;

endmodule

`default_nettype wire

@@ rtl/affine_voxel_resample_index.sv @@
// Affine voxel resample index
//
// The req channel takes one reference voxel coordinate per word (ref_x, ref_y,
// ref_z). The block maps it through the affine map in the csr registers, rounds
// each axis to the nearest integer (ties to even), checks it against the moving
// extents and returns one rsp word with the linear moving index and an in-bounds
// flag. Out-of-bounds words carry index zero.
// Each accepted word passes through five registers in order: the input register,
// the product, round-and-bound and row-offset registers, and the result register.
// Throughput is one word per cycle; the pipeline is a single shift chain that
// advances whenever the result register is empty or being taken.
// When the receiver stalls with a word held, the whole chain freezes and
// req_ready drops in the same cycle; nothing is dropped or repeated.
// Reset empties the pipeline and loads the identity map with zero extents, so
// every word is out of bounds until the extents are written. Write csr
// registers only while no word is in flight.
`default_nettype none

module affine_voxel_resample_index (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [avri_pkg::COORD_BITS-1:0]     req_ref_x,
   input  wire logic [avri_pkg::COORD_BITS-1:0]     req_ref_y,
   input  wire logic [avri_pkg::COORD_BITS-1:0]     req_ref_z,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [avri_pkg::IDX_BITS-1:0]            rsp_moving_index,
   output logic                                     rsp_in_bounds,
   input  wire logic                                csr_wr_en,
   input  wire logic [avri_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  wire logic [avri_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import avri_pkg::*;

   logic [CSR_DATA_BITS-1:0] map_x_lo_ff, map_x_hi_ff, map_y_lo_ff;
   logic [CSR_DATA_BITS-1:0] map_y_hi_ff, map_z_lo_ff, map_z_hi_ff;
   logic [EXTENTS_BITS-1:0]  extents_ff;
   logic [EXT_BITS-1:0]      ext_x, ext_y, ext_z;

   logic                     advance;
   logic [3:0]               valid_ff, valid_in;
   logic                     rsp_valid_ff;
   logic [COORD_BITS-1:0]    ref_x_ff, ref_y_ff, ref_z_ff;
   axis_pos_type             pos_x, pos_y, pos_z;

   // Configuration writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         map_x_lo_ff <= RST_MAP_X_LO;
         map_x_hi_ff <= RST_MAP_X_HI;
         map_y_lo_ff <= RST_MAP_Y_LO;
         map_y_hi_ff <= RST_MAP_Y_HI;
         map_z_lo_ff <= RST_MAP_Z_LO;
         map_z_hi_ff <= RST_MAP_Z_HI;
         extents_ff <= RST_EXTENTS;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAP_X_LO: map_x_lo_ff <= csr_wdata;
            CSR_MAP_X_HI: map_x_hi_ff <= csr_wdata;
            CSR_MAP_Y_LO: map_y_lo_ff <= csr_wdata;
            CSR_MAP_Y_HI: map_y_hi_ff <= csr_wdata;
            CSR_MAP_Z_LO: map_z_lo_ff <= csr_wdata;
            CSR_MAP_Z_HI: map_z_hi_ff <= csr_wdata;
            CSR_EXTENTS:  extents_ff <= csr_wdata[EXTENTS_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign ext_x = extents_ff[EXT_BITS-1:0];
   assign ext_y = extents_ff[2*EXT_BITS-1:EXT_BITS];
   assign ext_z = extents_ff[3*EXT_BITS-1:2*EXT_BITS];

   // Shift the whole chain whenever the result register can take a word
   assign advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign valid_in = {valid_ff[2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
         rsp_valid_ff <= valid_ff[3];
      end
   end

   // Hold the accepted coordinate
   always_ff @(posedge clock) begin
      if (advance) begin
         ref_x_ff <= req_ref_x;
         ref_y_ff <= req_ref_y;
         ref_z_ff <= req_ref_z;
      end
   end

   avri_axis u_axis_x (
      .clock    (clock),
      .advance  (advance),
      .ref_x    (ref_x_ff),
      .ref_y    (ref_y_ff),
      .ref_z    (ref_z_ff),
      .row_lo   (map_x_lo_ff),
      .row_hi   (map_x_hi_ff),
      .extent   (ext_x),
      .axis_out (pos_x)
   );

   avri_axis u_axis_y (
      .clock    (clock),
      .advance  (advance),
      .ref_x    (ref_x_ff),
      .ref_y    (ref_y_ff),
      .ref_z    (ref_z_ff),
      .row_lo   (map_y_lo_ff),
      .row_hi   (map_y_hi_ff),
      .extent   (ext_y),
      .axis_out (pos_y)
   );

   avri_axis u_axis_z (
      .clock    (clock),
      .advance  (advance),
      .ref_x    (ref_x_ff),
      .ref_y    (ref_y_ff),
      .ref_z    (ref_z_ff),
      .row_lo   (map_z_lo_ff),
      .row_hi   (map_z_hi_ff),
      .extent   (ext_z),
      .axis_out (pos_z)
   );

   avri_index u_index (
      .clock        (clock),
      .advance      (advance),
      .pos_x        (pos_x),
      .pos_y        (pos_y),
      .pos_z        (pos_z),
      .extent_x     (ext_x),
      .extent_y     (ext_y),
      .moving_index (rsp_moving_index),
      .in_bounds    (rsp_in_bounds)
   );

   assign rsp_valid = rsp_valid_ff;

   // An out-of-bounds word never carries a nonzero index
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_in_bounds) |-> (rsp_moving_index == '0))
      else $error("out-of-bounds word with nonzero index");

   // An in-bounds word needs a nonempty moving volume
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_in_bounds) |-> ((ext_x != '0) && (ext_y != '0) && (ext_z != '0)))
      else $error("in-bounds word with empty moving volume");

   // The input side never stalls while the result register is empty
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled with empty result register");

   // A word in the last stage reaches the result register on the next advance
   assert property (@(posedge clock) disable iff (reset)
      (advance && valid_ff[3]) |=> rsp_valid_ff)
      else $error("word lost between last stage and result register");

   // Reset leaves the pipeline empty
   assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && (valid_ff == '0)))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

@@ dv/resample_index_checker.sv @@
`default_nettype none

module resample_index_checker (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   input  wire logic                               req_ready,
   input  wire logic [avri_pkg::COORD_BITS-1:0]    req_ref_x,
   input  wire logic [avri_pkg::COORD_BITS-1:0]    req_ref_y,
   input  wire logic [avri_pkg::COORD_BITS-1:0]    req_ref_z,
   input  wire logic                               rsp_valid,
   input  wire logic                               rsp_ready,
   input  wire logic [avri_pkg::IDX_BITS-1:0]      rsp_moving_index,
   input  wire logic                               rsp_in_bounds,
   input  wire logic                               csr_wr_en,
   input  wire logic [avri_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [avri_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int                                      fail_count,
   output int                                      pending_count
);
   import avri_pkg::*;

   typedef struct packed {
      logic [IDX_BITS-1:0] moving_index;
      logic                in_bounds;
   } index_word_type;

   // Shadow copy of the map rows (x, y, z) and the moving extents
   logic [CSR_DATA_BITS-1:0] map_lo [3];
   logic [CSR_DATA_BITS-1:0] map_hi [3];
   logic [EXTENTS_BITS-1:0]  extents;
   index_word_type           expected_index_q [$];

   // Evaluate one map row exactly, then round to nearest with ties to even
   function automatic longint round_map_row(input logic [CSR_DATA_BITS-1:0] lo,
                                            input logic [CSR_DATA_BITS-1:0] hi,
                                            input logic [COORD_BITS-1:0]    x,
                                            input logic [COORD_BITS-1:0]    y,
                                            input logic [COORD_BITS-1:0]    z);
      longint               sum;
      longint               whole;
      logic [FRAC_BITS-1:0] frac;
      sum = longint'($signed(lo[COEF_BITS-1:0])) * longint'(x)
          + longint'($signed(lo[2*COEF_BITS-1:COEF_BITS])) * longint'(y)
          + longint'($signed(hi[COEF_BITS-1:0])) * longint'(z)
          + longint'($signed(hi[2*COEF_BITS-1:COEF_BITS]));
      whole = sum >>> FRAC_BITS;
      frac  = sum[FRAC_BITS-1:0];
      if (frac > HALF_UNIT || (frac == HALF_UNIT && whole[0])) begin
         whole = whole + 1;
      end
      return whole;
   endfunction

   // Map one coordinate, bound it against the extents and form the linear index
   function automatic index_word_type predict_index(input logic [COORD_BITS-1:0] x,
                                                    input logic [COORD_BITS-1:0] y,
                                                    input logic [COORD_BITS-1:0] z);
      index_word_type word;
      longint         pos [3];
      longint         ext_len [3];
      logic [63:0]    linear;
      for (int a = 0; a < 3; a++) begin
         pos[a]     = round_map_row(map_lo[a], map_hi[a], x, y, z);
         ext_len[a] = longint'(extents[a*EXT_BITS +: EXT_BITS]);
      end
      word.in_bounds = pos[0] >= 0 && pos[0] < ext_len[0]
                    && pos[1] >= 0 && pos[1] < ext_len[1]
                    && pos[2] >= 0 && pos[2] < ext_len[2];
      linear = '0;
      if (word.in_bounds) begin
         linear = pos[2] * ext_len[1] * ext_len[0] + pos[1] * ext_len[0] + pos[0];
      end
      word.moving_index = linear[IDX_BITS-1:0];
      return word;
   endfunction

   always @(posedge clock) begin
      index_word_type oldest;
      int             errs;
      errs = 0;
      if (reset) begin
         map_lo[0] <= RST_MAP_X_LO;
         map_hi[0] <= RST_MAP_X_HI;
         map_lo[1] <= RST_MAP_Y_LO;
         map_hi[1] <= RST_MAP_Y_HI;
         map_lo[2] <= RST_MAP_Z_LO;
         map_hi[2] <= RST_MAP_Z_HI;
         extents   <= RST_EXTENTS;
         expected_index_q.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         // track register writes; unknown indexes are dropped
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MAP_X_LO: map_lo[0] <= csr_wdata;
               CSR_MAP_X_HI: map_hi[0] <= csr_wdata;
               CSR_MAP_Y_LO: map_lo[1] <= csr_wdata;
               CSR_MAP_Y_HI: map_hi[1] <= csr_wdata;
               CSR_MAP_Z_LO: map_lo[2] <= csr_wdata;
               CSR_MAP_Z_HI: map_hi[2] <= csr_wdata;
               CSR_EXTENTS:  extents   <= csr_wdata[EXTENTS_BITS-1:0];
               default: ;
            endcase
         end
         // check the result word against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_index_q.size() == 0) begin
               $display("%0t: result word with nothing expected: moving_index %h in_bounds %b",
                        $time, rsp_moving_index, rsp_in_bounds);
               errs++;
            end else begin
               oldest = expected_index_q.pop_front();
               if (rsp_moving_index !== oldest.moving_index) begin
                  $display("%0t: moving_index mismatch: expected %h, actual %h",
                           $time, oldest.moving_index, rsp_moving_index);
                  errs++;
               end
               if (rsp_in_bounds !== oldest.in_bounds) begin
                  $display("%0t: in_bounds mismatch: expected %b, actual %b",
                           $time, oldest.in_bounds, rsp_in_bounds);
                  errs++;
               end
            end
         end
         // predict each accepted coordinate word
         if (req_valid && req_ready) begin
            expected_index_q = {expected_index_q,
                                predict_index(req_ref_x, req_ref_y, req_ref_z)};
         end
         fail_count    <= fail_count + errs;
         pending_count <= expected_index_q.size();
      end
   end

endmodule

`default_nettype wire

@@ dv/tb_affine_voxel_resample_index.sv @@
`default_nettype none

module tb_affine_voxel_resample_index;
   import avri_pkg::*;

   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 95;
   localparam int Q_ONE           = 1 << FRAC_BITS;
   localparam logic [CSR_IDX_BITS-1:0] CSR_UNMAPPED = 3'd7;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] x_lo;
      logic [CSR_DATA_BITS-1:0] x_hi;
      logic [CSR_DATA_BITS-1:0] y_lo;
      logic [CSR_DATA_BITS-1:0] y_hi;
      logic [CSR_DATA_BITS-1:0] z_lo;
      logic [CSR_DATA_BITS-1:0] z_hi;
      logic [EXTENTS_BITS-1:0]  extents;
   } map_setting_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [COORD_BITS-1:0]    req_ref_x = '0;
   logic [COORD_BITS-1:0]    req_ref_y = '0;
   logic [COORD_BITS-1:0]    req_ref_z = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b1;
   logic [IDX_BITS-1:0]      rsp_moving_index;
   logic                     rsp_in_bounds;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;
   int                       fail_count;
   int                       pending_count;
   int                       req_gap_pct = 0;
   int                       rsp_stall_pct = 0;
   int                       quiet_cycles = 0;

   affine_voxel_resample_index dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ref_x        (req_ref_x),
      .req_ref_y        (req_ref_y),
      .req_ref_z        (req_ref_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_moving_index (rsp_moving_index),
      .rsp_in_bounds    (rsp_in_bounds),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   resample_index_checker index_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ref_x        (req_ref_x),
      .req_ref_y        (req_ref_y),
      .req_ref_z        (req_ref_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_moving_index (rsp_moving_index),
      .rsp_in_bounds    (rsp_in_bounds),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always #2 clock = ~clock;

   // Stall the result side in random bursts
   always begin
      @(negedge clock);
      if ($urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_ready = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      rsp_ready = 1'b1;
   end

   // End the run when no word moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [CSR_DATA_BITS-1:0] pack_row(input logic [COEF_BITS-1:0] first,
                                                        input logic [COEF_BITS-1:0] second);
      return {second, first};
   endfunction

   function automatic map_setting_type map_setting(input logic [CSR_DATA_BITS-1:0] x_lo,
                                                   input logic [CSR_DATA_BITS-1:0] x_hi,
                                                   input logic [CSR_DATA_BITS-1:0] y_lo,
                                                   input logic [CSR_DATA_BITS-1:0] y_hi,
                                                   input logic [CSR_DATA_BITS-1:0] z_lo,
                                                   input logic [CSR_DATA_BITS-1:0] z_hi,
                                                   input logic [EXTENTS_BITS-1:0]  ext);
      map_setting_type s;
      s.x_lo    = x_lo;
      s.x_hi    = x_hi;
      s.y_lo    = y_lo;
      s.y_hi    = y_hi;
      s.z_lo    = z_lo;
      s.z_hi    = z_hi;
      s.extents = ext;
      return s;
   endfunction

   // Signed coefficient in [-lim, lim]; coarse ones round down to quarter steps (may go below -lim) to hit ties
   function automatic logic [COEF_BITS-1:0] rand_coef(input int unsigned lim, input bit coarse);
      int v;
      v = int'($urandom_range(0, 2 * lim)) - int'(lim);
      if (coarse) begin
         v = v & 32'hFFFF_C000;
      end
      return v;
   endfunction

   // Mostly a near-diagonal map that lands inside extents sized to the span
   function automatic map_setting_type random_setting(input int unsigned span, input bit raw);
      map_setting_type s;
      bit              coarse;
      int unsigned     off_lim;
      coarse  = 1'($urandom_range(0, 1));
      off_lim = (span + 4) * Q_ONE;
      if (raw) begin
         s = map_setting({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                         EXTENTS_BITS'({$urandom, $urandom}));
      end else begin
         s.x_lo = pack_row(rand_coef(2 * Q_ONE, coarse), rand_coef(Q_ONE / 8, coarse));
         s.x_hi = pack_row(rand_coef(Q_ONE / 8, coarse), rand_coef(off_lim, coarse));
         s.y_lo = pack_row(rand_coef(Q_ONE / 8, coarse), rand_coef(2 * Q_ONE, coarse));
         s.y_hi = pack_row(rand_coef(Q_ONE / 8, coarse), rand_coef(off_lim, coarse));
         s.z_lo = pack_row(rand_coef(Q_ONE / 8, coarse), rand_coef(Q_ONE / 8, coarse));
         s.z_hi = pack_row(rand_coef(2 * Q_ONE, coarse), rand_coef(off_lim, coarse));
         s.extents = {EXT_BITS'($urandom_range(1, 2 * span + 2)),
                      EXT_BITS'($urandom_range(1, 2 * span + 2)),
                      EXT_BITS'($urandom_range(1, 2 * span + 2))};
      end
      return s;
   endfunction

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0]  idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
   endtask

   // Hold the sender until every expected result word has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Load all registers while idle; the extra write to an unused index must be dropped
   task automatic load_map(input map_setting_type s);
      wait_drained();
      csr_write(CSR_MAP_X_LO, s.x_lo);
      csr_write(CSR_MAP_X_HI, s.x_hi);
      csr_write(CSR_MAP_Y_LO, s.y_lo);
      csr_write(CSR_MAP_Y_HI, s.y_hi);
      csr_write(CSR_MAP_Z_LO, s.z_lo);
      csr_write(CSR_MAP_Z_HI, s.z_hi);
      csr_write(CSR_EXTENTS, {16'($urandom), s.extents});
      csr_write(CSR_UNMAPPED, {$urandom, $urandom});
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic send_coord(input logic [COORD_BITS-1:0] x,
                             input logic [COORD_BITS-1:0] y,
                             input logic [COORD_BITS-1:0] z);
      @(negedge clock);
      if ($urandom_range(0, 99) < req_gap_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_ref_x = x;
      req_ref_y = y;
      req_ref_z = z;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin
      map_setting_type setting;
      int unsigned     span;
      repeat (10) @(negedge clock);
      reset = 1'b0;
      req_gap_pct   = 10;
      rsp_stall_pct = 10;

      // zero extents after reset: everything out of bounds
      send_coord(0, 0, 0);
      send_coord(4095, 4095, 4095);

      // identity map over a full 4096 cube: corners reach the top index
      load_map(map_setting(RST_MAP_X_LO, RST_MAP_X_HI, RST_MAP_Y_LO, RST_MAP_Y_HI,
                           RST_MAP_Z_LO, RST_MAP_Z_HI, {16'd4096, 16'd4096, 16'd4096}));
      send_coord(0, 0, 0);
      send_coord(4095, 0, 0);
      send_coord(0, 4095, 0);
      send_coord(0, 0, 4095);
      send_coord(4095, 4095, 4095);

      // half steps: ties to even in both signs, just past half, edges of an 8 cube
      load_map(map_setting(pack_row(32'h0000_8000, 0), '0,
                           pack_row(0, 32'hFFFF_8000), pack_row(0, 4 * Q_ONE),
                           '0, pack_row(Q_ONE, 32'h0000_8001),
                           {16'd8, 16'd8, 16'd8}));
      send_coord(1, 1, 0);
      send_coord(3, 3, 1);
      send_coord(5, 5, 2);
      send_coord(7, 9, 3);
      send_coord(15, 11, 0);
      send_coord(0, 11, 0);
      send_coord(0, 0, 7);
      send_coord(14, 0, 6);

      // largest extents: the index wraps to its low bits
      load_map(map_setting(RST_MAP_X_LO, RST_MAP_X_HI, RST_MAP_Y_LO, RST_MAP_Y_HI,
                           RST_MAP_Z_LO, RST_MAP_Z_HI, '1));
      send_coord(0, 0, 0);
      send_coord(4095, 4095, 4095);

      // most positive and most negative coefficients and offsets
      load_map(map_setting(pack_row(32'h7FFF_FFFF, 32'h8000_0000),
                           pack_row(32'h0000_0000, 32'h7FFF_FFFF),
                           pack_row(32'h8000_0000, 32'h7FFF_FFFF),
                           pack_row(32'h7FFF_FFFF, 32'h0000_0000),
                           '0, pack_row(32'h8000_0000, 32'h7FFF_FFFF), '1));
      send_coord(0, 0, 0);
      send_coord(4095, 4095, 4095);
      send_coord(4095, 0, 4095);

      // random maps; one phase and the last run with no idling
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 3))
            0:       span = 7;
            1:       span = 63;
            2:       span = 255;
            default: span = 4095;
         endcase
         setting = random_setting(span, phase == 3);
         load_map(setting);
         if (phase == 1 || phase == RANDOM_PHASES - 1) begin
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end else begin
            req_gap_pct   = $urandom_range(3, 25);
            rsp_stall_pct = $urandom_range(2, 15);
         end
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 99) < 85) begin
               send_coord(COORD_BITS'($urandom_range(0, span)),
                          COORD_BITS'($urandom_range(0, span)),
                          COORD_BITS'($urandom_range(0, span)));
            end else begin
               send_coord(COORD_BITS'($urandom), COORD_BITS'($urandom),
                          COORD_BITS'($urandom));
            end
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
